// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the counter prescale/scale/compare top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define CPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising clk_i edge, reset included.
`define CPSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/cpsc_pkg.sv -----
// Shared types, codes and helpers for the counter prescale/scale/compare block.
package cpsc_pkg;

  // Channel count and field widths
  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned CH_W      = 2;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned PRE_W     = 16;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DIV_CNT_W = $clog2(VAL_W);

  // Stream layout
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 128;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PRESCALER = 3'd0,
    REG_SCALE     = 3'd1,
    REG_WIDTH     = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_MODE      = 3'd4,
    REG_SOURCE    = 3'd5,
    REG_ENABLE    = 3'd6,
    REG_START     = 3'd7
  } reg_idx_e;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  // Output width codes
  localparam logic [1:0] WS_8  = 2'd0;
  localparam logic [1:0] WS_16 = 2'd1;
  localparam logic [1:0] WS_32 = 2'd2;
  localparam logic [1:0] WS_64 = 2'd3;

  // Compare modes
  localparam logic [1:0] MODE_GE     = 2'd0;
  localparam logic [1:0] MODE_GT     = 2'd1;
  localparam logic [1:0] MODE_GE_ALT = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Compare sources
  localparam logic [1:0] SRC_RAW     = 2'd0;
  localparam logic [1:0] SRC_PRE     = 2'd1;
  localparam logic [1:0] SRC_SCALED  = 2'd2;
  localparam logic [1:0] SRC_RAW_ALT = 2'd3;

  // Scale factor that stands for 1.0, and the rounding half in 16.16
  localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0001_0000;
  localparam logic [VAL_W-1:0]   ROUND_HALF = 64'h0000_0000_0000_8000;

  // Configuration register set
  typedef struct packed {
    logic [PRE_W-1:0]   prescaler;
    logic [SCALE_W-1:0] scale_q16;
    logic [1:0]         width_select;
    logic [VAL_W-1:0]   threshold;
    logic [1:0]         cmp_mode;
    logic [1:0]         cmp_src;
    logic               compare_on;
    logic [VAL_W-1:0]   rearm_value;
  } cfg_t;

  // Status of an arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Largest value of the selected output width
  function automatic logic [VAL_W-1:0] width_max(input logic [1:0] ws);
    logic [VAL_W-1:0] m;
    unique case (ws)
      WS_8:    m = 64'h0000_0000_0000_00FF;
      WS_16:   m = 64'h0000_0000_0000_FFFF;
      WS_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/counter_prescale_scale_compare_unit.sv -----
// A sample request runs through ST_RUN, ST_CMP and ST_OUT; a reset request skips ST_RUN.
// Requests are taken only in ST_IDLE; a sample waits for the 64-step bit-serial divider,
// while the 16.16 scaler (one shared 32x32 multiplier) runs beside it.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) loads register defaults and clears all last values.
// Top level of the counter prescale/scale/compare block.
`include "assert_macros.svh"

module counter_prescale_scale_compare_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [cpsc_pkg::IDX_W-1:0]          cfg_addr_i,
  input  logic [cpsc_pkg::VAL_W-1:0]          cfg_wdata_i,
  // Request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cpsc_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // channel[1:0], count[65:2], zero
  input  logic                                s_axis_tuser,  // op
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cpsc_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // scaled[63:0], prescaled[127:64]
  output logic                                m_axis_tuser   // hit
);

  localparam int unsigned VW = cpsc_pkg::VAL_W;
  localparam int unsigned CW = cpsc_pkg::CH_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_CMP,
    ST_OUT
  } state_e;

  cpsc_pkg::cfg_t          cfg;
  cpsc_pkg::unit_stat_t    div_stat;
  cpsc_pkg::unit_stat_t    scale_stat;

  state_e                  state_q;
  logic                    op_q;
  logic [CW-1:0]           ch_q;
  logic [VW-1:0]           count_q;
  logic [VW-1:0]           last_q [cpsc_pkg::CHANNELS];
  logic [VW-1:0]           res_scaled_q;
  logic [VW-1:0]           res_pre_q;
  logic                    res_hit_q;
  logic                    m_valid_q;
  logic [VW-1:0]           m_scaled_q;
  logic [VW-1:0]           m_pre_q;
  logic                    m_hit_q;

  logic                    accept;
  logic                    start;
  logic                    out_free;
  logic [CW-1:0]           in_ch;
  logic [VW-1:0]           in_count;
  logic [VW-1:0]           quotient;
  logic [VW-1:0]           scaled;
  logic [VW-1:0]           pre;
  logic [VW-1:0]           maxv;
  logic [VW-1:0]           src;
  logic [VW-1:0]           last;
  logic                    last_lt, last_le, src_ge, src_gt;
  logic                    hit;

  // Unpack the request
  assign in_ch    = s_axis_tdata[CW-1:0];
  assign in_count = s_axis_tdata[CW+VW-1:CW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && (s_axis_tuser == cpsc_pkg::OP_SAMPLE);
  assign out_free      = !m_valid_q || m_axis_tready;

  cpsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  cpsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (in_count),
    .divisor_i  (cfg.prescaler),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  cpsc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .count_i     (in_count),
    .scale_i     (cfg.scale_q16),
    .width_sel_i (cfg.width_select),
    .scaled_o    (scaled),
    .stat_o      (scale_stat)
  );

  // Pick the compare source and detect the threshold crossing
  always_comb begin
    pre  = (cfg.prescaler > 16'd1) ? quotient : count_q;
    maxv = cpsc_pkg::width_max(cfg.width_select);
    case (cfg.cmp_src)
      cpsc_pkg::SRC_PRE:    src = pre;
      cpsc_pkg::SRC_SCALED: src = scaled;
      default:              src = count_q;
    endcase
    last    = last_q[ch_q];
    last_lt = last < cfg.threshold;
    last_le = last <= cfg.threshold;
    src_ge  = src >= cfg.threshold;
    src_gt  = src > cfg.threshold;
    case (cfg.cmp_mode) inside
      cpsc_pkg::MODE_GE, cpsc_pkg::MODE_GE_ALT: hit = last_lt && src_ge;
      cpsc_pkg::MODE_GT:                        hit = last_le && src_gt;
      default:                                  hit = 1'b0;
    endcase
  end

  // Sequencer, per-channel tracking and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= cpsc_pkg::OP_SAMPLE;
      ch_q         <= '0;
      count_q      <= '0;
      res_scaled_q <= '0;
      res_pre_q    <= '0;
      res_hit_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      m_scaled_q   <= '0;
      m_pre_q      <= '0;
      m_hit_q      <= 1'b0;
      for (int i = 0; i < cpsc_pkg::CHANNELS; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      // Drop a result once taken, unless a new one moves in
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= s_axis_tuser;
            ch_q    <= in_ch;
            count_q <= in_count;
            state_q <= (s_axis_tuser == cpsc_pkg::OP_RESET) ? ST_CMP : ST_RUN;
          end
        end
        ST_RUN: begin
          if (div_stat.done) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (op_q == cpsc_pkg::OP_RESET) begin
            last_q[ch_q] <= cfg.rearm_value;
            res_scaled_q <= '0;
            res_pre_q    <= '0;
            res_hit_q    <= 1'b0;
          end else begin
            res_scaled_q <= scaled;
            res_pre_q    <= pre & maxv;
            res_hit_q    <= cfg.compare_on && hit;
            if (cfg.compare_on) begin
              last_q[ch_q] <= src;
            end
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Advance into the output register when it frees up
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_scaled_q <= res_scaled_q;
            m_pre_q    <= res_pre_q;
            m_hit_q    <= res_hit_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_pre_q, m_scaled_q};
  assign m_axis_tuser  = m_hit_q;

  // Divider finishes only while the sequencer waits for it
  `CPSC_ASSERT(a_div_done_in_run, div_stat.done |-> state_q == ST_RUN, "divider done outside run")
  // Scaler result is ready before the quotient
  `CPSC_ASSERT(a_scale_first, div_stat.done |-> !scale_stat.busy, "scaler still busy at divide end")
  // Both units are idle whenever a request can be taken
  `CPSC_ASSERT(a_ready_units_idle, s_axis_tready |-> !div_stat.busy && !scale_stat.busy, "unit busy while ready")

endmodule

// ----- rtl/core/cpsc_cfg.sv -----
// Configuration register file of the counter prescale/scale/compare block.
module cpsc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [cpsc_pkg::IDX_W-1:0]    addr_i,
  input  logic [cpsc_pkg::VAL_W-1:0]    wdata_i,
  output cpsc_pkg::cfg_t                cfg_o
);

  cpsc_pkg::cfg_t cfg_q;

  // Decode the index and load the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescaler      <= 16'd1;
      cfg_q.scale_q16      <= cpsc_pkg::SCALE_ONE;
      cfg_q.width_select   <= cpsc_pkg::WS_64;
      cfg_q.threshold      <= '0;
      cfg_q.cmp_mode       <= cpsc_pkg::MODE_GE;
      cfg_q.cmp_src        <= cpsc_pkg::SRC_RAW;
      cfg_q.compare_on     <= 1'b0;
      cfg_q.rearm_value    <= '0;
    end else if (we_i) begin
      unique case (addr_i)
        cpsc_pkg::REG_PRESCALER: cfg_q.prescaler      <= wdata_i[cpsc_pkg::PRE_W-1:0];
        cpsc_pkg::REG_SCALE:     cfg_q.scale_q16      <= wdata_i[cpsc_pkg::SCALE_W-1:0];
        cpsc_pkg::REG_WIDTH:     cfg_q.width_select   <= wdata_i[1:0];
        cpsc_pkg::REG_THRESHOLD: cfg_q.threshold      <= wdata_i;
        cpsc_pkg::REG_MODE:      cfg_q.cmp_mode       <= wdata_i[1:0];
        cpsc_pkg::REG_SOURCE:    cfg_q.cmp_src        <= wdata_i[1:0];
        cpsc_pkg::REG_ENABLE:    cfg_q.compare_on     <= wdata_i[0];
        cpsc_pkg::REG_START:     cfg_q.rearm_value    <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/cpsc_div.sv -----
// Radix-2 restoring divider: 64-bit count by 16-bit prescaler, one bit per cycle.
module cpsc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cpsc_pkg::VAL_W-1:0]    dividend_i,
  input  logic [cpsc_pkg::PRE_W-1:0]    divisor_i,
  output logic [cpsc_pkg::VAL_W-1:0]    quotient_o,
  output cpsc_pkg::unit_stat_t          stat_o
);

  localparam logic [cpsc_pkg::DIV_CNT_W-1:0] LastStep =
    cpsc_pkg::DIV_CNT_W'(cpsc_pkg::VAL_W - 1);

  logic                              busy_q;
  logic                              done_q;
  logic [cpsc_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [cpsc_pkg::PRE_W-1:0]        rem_q, rem_d;
  logic [cpsc_pkg::PRE_W-1:0]        dvs_q;
  logic [cpsc_pkg::VAL_W-1:0]        quo_q, quo_d;
  logic [cpsc_pkg::PRE_W:0]          partial;
  logic [cpsc_pkg::PRE_W:0]          diff;
  logic                              ge;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    partial = {rem_q, quo_q[cpsc_pkg::VAL_W-1]};
    diff    = partial - {1'b0, dvs_q};
    ge      = partial >= {1'b0, dvs_q};
    rem_d   = ge ? diff[cpsc_pkg::PRE_W-1:0] : partial[cpsc_pkg::PRE_W-1:0];
    quo_d   = {quo_q[cpsc_pkg::VAL_W-2:0], ge};
  end

  // Step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- rtl/core/cpsc_scale.sv -----
// 16.16 scaler: two passes through one 32x32 multiplier, round, then clamp.
module cpsc_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cpsc_pkg::VAL_W-1:0]    count_i,
  input  logic [cpsc_pkg::SCALE_W-1:0]  scale_i,
  input  logic [1:0]                    width_sel_i,
  output logic [cpsc_pkg::VAL_W-1:0]    scaled_o,
  output cpsc_pkg::unit_stat_t          stat_o
);

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_LO,
    SC_HI,
    SC_SUM
  } sc_state_e;

  sc_state_e                         state_q;
  logic                              done_q;
  logic [cpsc_pkg::VAL_W-1:0]        cnt_q;
  logic [cpsc_pkg::SCALE_W-1:0]      s_q;
  logic [cpsc_pkg::VAL_W-1:0]        maxv_q;
  logic [cpsc_pkg::VAL_W-1:0]        plo_q;
  logic [cpsc_pkg::VAL_W-1:0]        phi_q;
  logic [cpsc_pkg::VAL_W-1:0]        res_q, res_d;
  logic [cpsc_pkg::SCALE_W-1:0]      mul_a;
  logic [cpsc_pkg::VAL_W-1:0]        prod;
  logic [cpsc_pkg::VAL_W:0]          sum;
  logic [cpsc_pkg::VAL_W-1:0]        shifted;

  // Shared multiplier: low count half first, then high half
  always_comb begin
    mul_a = (state_q == SC_HI) ? cnt_q[cpsc_pkg::VAL_W-1:cpsc_pkg::SCALE_W]
                               : cnt_q[cpsc_pkg::SCALE_W-1:0];
    prod  = mul_a * s_q;
  end

  // Combine the partial products and clamp to the width maximum
  always_comb begin
    shifted = {phi_q[47:0], 16'h0000};
    sum     = {1'b0, shifted} + {17'b0, plo_q[cpsc_pkg::VAL_W-1:16]};
    if (phi_q[cpsc_pkg::VAL_W-1:48] != '0 || sum[cpsc_pkg::VAL_W]) begin
      res_d = maxv_q;
    end else if (sum[cpsc_pkg::VAL_W-1:0] > maxv_q) begin
      res_d = maxv_q;
    end else begin
      res_d = sum[cpsc_pkg::VAL_W-1:0];
    end
  end

  // Sequence the passes and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      s_q     <= '0;
      maxv_q  <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      res_q   <= '0;
    end else begin
      done_q <= (state_q == SC_SUM);
      unique case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            cnt_q   <= count_i;
            s_q     <= (scale_i == '0) ? cpsc_pkg::SCALE_ONE : scale_i;
            maxv_q  <= cpsc_pkg::width_max(width_sel_i);
            state_q <= SC_LO;
          end
        end
        SC_LO: begin
          plo_q   <= prod;
          state_q <= SC_HI;
        end
        SC_HI: begin
          phi_q   <= prod;
          plo_q   <= plo_q + cpsc_pkg::ROUND_HALF;
          state_q <= SC_SUM;
        end
        SC_SUM: begin
          res_q   <= res_d;
          state_q <= SC_IDLE;
        end
        default: state_q <= SC_IDLE;
      endcase
    end
  end

  assign scaled_o    = res_q;
  assign stat_o.busy = (state_q != SC_IDLE);
  assign stat_o.done = done_q;

endmodule
